@@ rtl/tcfd_pkg.sv @@
package tcfd_pkg;

    // Framing and command codes.
    localparam logic [7:0] FRAME_RESTART = 8'hFF;
    localparam logic [7:0] CMD_ENABLE    = 8'hF0;
    localparam logic [7:0] CMD_DISABLE   = 8'hF1;
    localparam logic [7:0] CMD_AUTOTUNE  = 8'hF2;
    localparam logic [7:0] REPLY_ACK0    = 8'hA0;
    localparam logic [7:0] REPLY_ACK1    = 8'hA1;

    // Item kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam int unsigned FREQ_W = 32;
    localparam logic [FREQ_W-1:0] FREQ_OFF = '1;

    // Byte positions within a three-byte command.
    localparam logic [1:0] POS_CODE = 2'd0;
    localparam logic [1:0] POS_HIGH = 2'd1;
    localparam logic [1:0] POS_LOW  = 2'd2;

    // Decoded item handed from the decoder to the response stage.
    typedef struct packed {
        logic              valid;
        logic [1:0]        count;     // number of response bytes, 0 to 2
        logic [7:0]        first_tx;  // first response byte
        logic              start;     // start_tune on the final byte
        logic              off;       // tuner_off on the final byte
        logic [FREQ_W-1:0] freq;      // stored frequency after the item
    } tcfd_rec_t;

    // Four packed-BCD digits, scaled to hertz (digit weights times 10000).
    function automatic logic [FREQ_W-1:0] decode_freq(input logic [7:0] hi,
                                                      input logic [7:0] lo);
        logic [FREQ_W-1:0] d0;
        logic [FREQ_W-1:0] d1;
        logic [FREQ_W-1:0] d2;
        logic [FREQ_W-1:0] d3;
        d0 = {{(FREQ_W-4){1'b0}}, lo[3:0]} * FREQ_W'(32'd10000);
        d1 = {{(FREQ_W-4){1'b0}}, lo[7:4]} * FREQ_W'(32'd100000);
        d2 = {{(FREQ_W-4){1'b0}}, hi[3:0]} * FREQ_W'(32'd1000000);
        d3 = {{(FREQ_W-4){1'b0}}, hi[7:4]} * FREQ_W'(32'd10000000);
        return d0 + d1 + d2 + d3;
    endfunction

endpackage

@@ rtl/tcfd_decode.sv @@
module tcfd_decode
    import tcfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             kind,
    input  logic [7:0]       rx_byte,
    input  logic             take,
    output tcfd_rec_t        rec
);

    logic              item_vld_reg;
    logic              item_vld_next;
    logic              kind_reg;
    logic [7:0]        byte_reg;
    logic [1:0]        byte_count_reg;
    logic [1:0]        byte_count_next;
    logic [7:0]        command_code_reg;
    logic [7:0]        command_code_next;
    logic [7:0]        bcd_high_reg;
    logic [7:0]        bcd_high_next;
    logic [FREQ_W-1:0] freq_reg;
    logic [FREQ_W-1:0] freq_next;
    logic              in_fire;
    logic              move;

    // The input register holds one item until the response stage takes it.
    assign move     = item_vld_reg && take;
    assign in_stall = item_vld_reg && !take;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        item_vld_next = item_vld_reg;
        if (in_fire)
        begin
            item_vld_next = 1'b1;
        end
        else if (move)
        begin
            item_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg <= kind;
            byte_reg <= rx_byte;
        end
    end

    // Framing and command decode for the held item.
    always_comb
    begin
        byte_count_next   = byte_count_reg;
        command_code_next = command_code_reg;
        bcd_high_next     = bcd_high_reg;
        freq_next         = freq_reg;
        rec.valid         = item_vld_reg;
        rec.count         = 2'd0;
        rec.first_tx      = REPLY_ACK0;
        rec.start         = 1'b0;
        rec.off           = 1'b0;
        if (kind_reg == KIND_DONE)
        begin
            rec.count    = 2'd1;
            rec.first_tx = REPLY_ACK1;
        end
        else if (byte_reg == FRAME_RESTART)
        begin
            byte_count_next = POS_CODE;
        end
        else
        begin
            unique case (byte_count_reg)
                POS_CODE:
                begin
                    command_code_next = byte_reg;
                    byte_count_next   = POS_HIGH;
                end
                POS_HIGH:
                begin
                    bcd_high_next   = byte_reg;
                    byte_count_next = POS_LOW;
                end
                default:
                begin
                    byte_count_next = POS_CODE;
                    unique case (command_code_reg)
                        CMD_ENABLE:
                        begin
                            freq_next = decode_freq(bcd_high_reg, byte_reg);
                            rec.count = 2'd2;
                        end
                        CMD_DISABLE:
                        begin
                            freq_next = FREQ_OFF;
                            rec.count = 2'd2;
                            rec.off   = 1'b1;
                        end
                        CMD_AUTOTUNE:
                        begin
                            freq_next = decode_freq(bcd_high_reg, byte_reg);
                            rec.count = 2'd1;
                            rec.start = 1'b1;
                        end
                        default:
                        begin
                            rec.count = 2'd0;
                        end
                    endcase
                end
            endcase
        end
        rec.freq = freq_next;
    end

    // Frame state advances when the item leaves for the response stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= POS_CODE;
            command_code_reg <= 8'd0;
            bcd_high_reg     <= 8'd0;
            freq_reg         <= '0;
        end
        else if (move)
        begin
            byte_count_reg   <= byte_count_next;
            command_code_reg <= command_code_next;
            bcd_high_reg     <= bcd_high_next;
            freq_reg         <= freq_next;
        end
    end

    // The byte position never reaches the unused code.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg != 2'd3)
        else $error("byte position out of range");

    // A held item that is not taken stays held.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_vld_reg && !take |=> item_vld_reg)
        else $error("held item lost");

    // An accepted transaction always lands in the input register.
    a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> item_vld_reg)
        else $error("accepted item not held");

endmodule

@@ rtl/tcfd_emit.sv @@
module tcfd_emit
    import tcfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tcfd_rec_t         rec,
    output logic              take,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        tx_byte,
    output logic              last,
    output logic              start_tune,
    output logic              tuner_off,
    output logic [FREQ_W-1:0] frequency_hz
);

    logic [1:0]        rem_reg;
    logic [1:0]        rem_next;
    logic              two_reg;
    logic [7:0]        first_tx_reg;
    logic              start_reg;
    logic              off_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic              out_fire;
    logic              load;

    assign out_valid = (rem_reg != 2'd0);
    assign out_fire  = out_valid && !out_stall;

    // Free when empty or when the final byte leaves in this cycle.
    assign take = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && !out_stall);
    assign load = take && rec.valid && (rec.count != 2'd0);

    always_comb
    begin
        rem_next = rem_reg;
        if (out_fire)
        begin
            rem_next = rem_reg - 2'd1;
        end
        if (load)
        begin
            rem_next = rec.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 2'd0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            two_reg      <= (rec.count == 2'd2);
            first_tx_reg <= rec.first_tx;
            start_reg    <= rec.start;
            off_reg      <= rec.off;
            freq_reg     <= rec.freq;
        end
    end

    // Response byte selection: the second byte of a pair is always ACK1.
    assign last         = (rem_reg == 2'd1);
    assign tx_byte      = (last && two_reg) ? REPLY_ACK1 : first_tx_reg;
    assign start_tune   = last && start_reg;
    assign tuner_off    = last && off_reg;
    assign frequency_hz = freq_reg;

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg != 2'd3)
        else $error("response count out of range");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid)
        else $error("loaded response not presented");

    a_pair_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && rem_reg == 2'd2 |=> rem_reg == 2'd1 && tx_byte == REPLY_ACK1)
        else $error("second response byte wrong");

    a_pulse_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (start_tune || tuner_off) |-> last)
        else $error("control pulse on a non-final byte");

endmodule

@@ rtl/tuner_command_frame_decoder.sv @@
// Tuner command frame decoder.
// Input channel (in_valid/in_stall): each transaction is either a received
// serial byte (kind 0, rx_byte) or a tuning-finished event (kind 1).
// Bytes are framed into three-byte commands; 0xFF restarts framing.
// Output channel (out_valid/out_stall): each transaction is one response
// byte with last, start_tune, tuner_off and the stored frequency_hz.
// Enable and disable commands give two response bytes, autotune and the
// tuning-finished event give one, all other items give none.
// The first response byte of an accepted input transaction passes through
// the input register, then the response register, before it is presented.
// Throughput: one item per cycle for items with zero or one response byte
// while the receiver does not stall; a two-byte response of an enable or
// disable command holds the response register until both of its bytes are
// taken, and the next item waits for it.
// Reset clears the byte position, command code, BCD byte and stored
// frequency to zero and empties both registers.
// When the receiver stalls, the current response byte holds steady; the
// input register can still take one item, and further input is stalled
// until the response register frees.
module tuner_command_frame_decoder
    import tcfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              kind,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        tx_byte,
    output logic              last,
    output logic              start_tune,
    output logic              tuner_off,
    output logic [FREQ_W-1:0] frequency_hz
);

    tcfd_rec_t rec;
    logic      take;

    tcfd_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .rx_byte  (rx_byte),
        .take     (take),
        .rec      (rec)
    );

    tcfd_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec          (rec),
        .take         (take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tx_byte      (tx_byte),
        .last         (last),
        .start_tune   (start_tune),
        .tuner_off    (tuner_off),
        .frequency_hz (frequency_hz)
    );

endmodule
